// ----- rtl/lacd_pkg.sv -----
// shared types and constants for the life automaton with cycle detection
`timescale 1ns / 1ps

package lacd_pkg;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDIT_OUT,
        ST_STEP,
        ST_CMP,
        ST_DRAIN,
        ST_UPD,
        ST_OUT
    } state_t;

    // request commands
    typedef enum logic [1:0] {
        CMD_STEP   = 2'd0,
        CMD_SET    = 2'd1,
        CMD_TOGGLE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    localparam int CMD_W      = 2;
    localparam int COORD_W    = 4;
    localparam int ROW_OUT_W  = 16;
    localparam int COUNT_W    = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STAGNANT_LIMIT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_RESET     = 4'd1;

    localparam logic [COUNT_W-1:0] COUNT_MAX     = 8'd255;
    localparam logic [COUNT_W-1:0] DEFAULT_LIMIT = 8'd10;

endpackage

// ----- rtl/lacd_row_unit.sv -----
// shared row unit: b3/s23 next row of a wrapped grid and a row equality compare
`timescale 1ns / 1ps

module lacd_row_unit #(
    parameter int GRID_SIDE = 16
) (
    input  logic [GRID_SIDE-1:0] up_row,
    input  logic [GRID_SIDE-1:0] mid_row,
    input  logic [GRID_SIDE-1:0] down_row,
    output logic [GRID_SIDE-1:0] next_row,
    input  logic [GRID_SIDE-1:0] cmp_a,
    input  logic [GRID_SIDE-1:0] cmp_b,
    output logic                 equal
);

    logic [GRID_SIDE-1:0] up_l, up_r, mid_l, mid_r, dn_l, dn_r;
    logic [3:0]           count [GRID_SIDE];

    // bit x of *_l holds column x-1, bit x of *_r holds column x+1, both wrapped
    assign up_l  = {up_row[GRID_SIDE-2:0], up_row[GRID_SIDE-1]};
    assign up_r  = {up_row[0], up_row[GRID_SIDE-1:1]};
    assign mid_l = {mid_row[GRID_SIDE-2:0], mid_row[GRID_SIDE-1]};
    assign mid_r = {mid_row[0], mid_row[GRID_SIDE-1:1]};
    assign dn_l  = {down_row[GRID_SIDE-2:0], down_row[GRID_SIDE-1]};
    assign dn_r  = {down_row[0], down_row[GRID_SIDE-1:1]};

    always_comb
    begin
        for (int x = 0; x < GRID_SIDE; x++)
        begin
            count[x] = 4'(up_l[x]) + 4'(up_row[x]) + 4'(up_r[x])
                     + 4'(mid_l[x]) + 4'(mid_r[x])
                     + 4'(dn_l[x]) + 4'(down_row[x]) + 4'(dn_r[x]);
            next_row[x] = (count[x] == 4'd3) || (mid_row[x] && (count[x] == 4'd2));
        end
    end

    assign equal = (cmp_a == cmp_b);

endmodule

// ----- rtl/lacd_hist_mem.sv -----
// history grid store with one valid bit per slot and registered read
`timescale 1ns / 1ps

module lacd_hist_mem #(
    parameter int HISTORY_DEPTH = 4,
    parameter int GRID_SIDE     = 16
) (
    input  logic                                                 clk,
    input  logic                                                 rst_n,
    input  logic                                                 wr_en,
    input  logic [((HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1)-1:0] wr_slot,
    input  logic [$clog2(GRID_SIDE)-1:0]                         wr_row,
    input  logic [GRID_SIDE-1:0]                                 wr_data,
    input  logic                                                 rd_en,
    input  logic [((HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1)-1:0] rd_slot,
    input  logic [$clog2(GRID_SIDE)-1:0]                         rd_row,
    output logic [GRID_SIDE-1:0]                                 rd_data
);

    localparam int ROW_W     = $clog2(GRID_SIDE);
    localparam int MEM_DEPTH = HISTORY_DEPTH * (2 ** ROW_W);

    logic [GRID_SIDE-1:0]     mem [0:MEM_DEPTH-1];
    logic [HISTORY_DEPTH-1:0] slot_valid_reg;
    logic [GRID_SIDE-1:0]     rd_data_reg;
    logic                     rd_valid_reg;

    // a slot never written reads as an empty grid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                slot_valid_reg[wr_slot] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= slot_valid_reg[rd_slot];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[{wr_slot, wr_row}] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[{rd_slot, rd_row}];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ----- rtl/life_automaton_with_cycle_detect_core.sv -----
// top level: wrapped life grid with edit commands, stepping and repeat detection
// set, toggle and clear present their row in the cycle after the request
// step: GRID_SIDE row updates, HISTORY_DEPTH*GRID_SIDE history row compares,
//   settling in ST_DRAIN and ST_UPD, then GRID_SIDE rows, one per cycle unless stalled
// one request at a time; the history compare reads through the single memory read port
// reset clears grid, history valid bits, slot, stagnant count; limit 10, auto-reset off
`timescale 1ns / 1ps

module life_automaton_with_cycle_detect_core #(
    parameter int HISTORY_DEPTH = 4,
    parameter int GRID_SIDE     = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // request channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [lacd_pkg::CMD_W-1:0]        command,
    input  logic [lacd_pkg::COORD_W-1:0]      cell_x,
    input  logic [lacd_pkg::COORD_W-1:0]      cell_y,
    input  logic                              cell_value,
    // row result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [lacd_pkg::COORD_W-1:0]      row_index,
    output logic [lacd_pkg::ROW_OUT_W-1:0]    row_bits,
    output logic                              changed,
    output logic                              repeating,
    output logic                              reset_due,
    output logic                              last,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lacd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lacd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import lacd_pkg::*;

    localparam int ROW_W  = $clog2(GRID_SIDE);
    localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(GRID_SIDE - 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HISTORY_DEPTH - 1);

    typedef logic [GRID_SIDE-1:0] row_t;

    state_t state_reg, state_next;

    // live grid; rotated a row per step or compare cycle, or per taken output row
    row_t grid_reg [GRID_SIDE];
    row_t grid_next [GRID_SIDE];

    row_t prev_row_reg, prev_row_next;     // original row above the tap
    row_t first_row_reg, first_row_next;   // original row 0, wraps under the last row
    logic [ROW_W-1:0]  row_cnt_reg, row_cnt_next;
    logic [SLOT_W-1:0] slot_cnt_reg, slot_cnt_next;   // history slot under compare
    logic [SLOT_W-1:0] hist_slot_reg, hist_slot_next; // next slot to store into
    logic [COUNT_W-1:0] stag_cnt_reg, stag_cnt_next;
    logic [COUNT_W-1:0] limit_reg;
    logic               auto_en_reg;
    logic chg_reg, chg_next;
    logic rep_reg, rep_next;

    // history compare pipeline
    logic slot_mism_reg, slot_mism_next;
    logic rd_vld_reg, rd_vld_next;
    logic rd_last_reg, rd_last_next;
    row_t cmp_row_reg, cmp_row_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [COORD_W-1:0]   out_idx_reg, out_idx_next;
    logic [ROW_OUT_W-1:0] out_bits_reg, out_bits_next;
    logic out_chg_reg, out_chg_next;
    logic out_rep_reg, out_rep_next;
    logic out_due_reg, out_due_next;
    logic out_last_reg, out_last_next;

    // row unit hookup
    row_t unit_down, unit_next_row, cmp_a, cmp_b;
    logic unit_equal;

    // history memory hookup
    logic              hist_wr_en, hist_rd_en;
    logic [SLOT_W-1:0] hist_rd_slot;
    logic [ROW_W-1:0]  hist_rd_row;
    row_t              hist_rd_data;

    // edit helpers
    logic             in_fire, out_fire;
    logic             cx_ok, cy_ok;
    logic [ROW_W-1:0] cy_idx;
    row_t             bit_mask, old_row, edited_row;
    logic [ROW_W-1:0] row_inc;
    logic             stagnant, due;
    logic [COUNT_W-1:0] count_upd;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign cfg_ready = 1'b1;

    assign out_valid = out_valid_reg;
    assign row_index = out_idx_reg;
    assign row_bits  = out_bits_reg;
    assign changed   = out_chg_reg;
    assign repeating = out_rep_reg;
    assign reset_due = out_due_reg;
    assign last      = out_last_reg;

    // the row under the tap borrows the saved row 0 on the final step cycle
    assign unit_down = (row_cnt_reg == ROW_LAST) ? first_row_reg : grid_reg[1];
    // step compares new row against old, compare phase checks history against grid
    assign cmp_a = (state_reg == ST_STEP) ? unit_next_row : hist_rd_data;
    assign cmp_b = (state_reg == ST_STEP) ? grid_reg[0] : cmp_row_reg;

    lacd_row_unit #(
        .GRID_SIDE (GRID_SIDE)
    ) u_row_unit (
        .up_row   (prev_row_reg),
        .mid_row  (grid_reg[0]),
        .down_row (unit_down),
        .next_row (unit_next_row),
        .cmp_a    (cmp_a),
        .cmp_b    (cmp_b),
        .equal    (unit_equal)
    );

    lacd_hist_mem #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .GRID_SIDE     (GRID_SIDE)
    ) u_hist_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (hist_wr_en),
        .wr_slot (hist_slot_reg),
        .wr_row  (row_cnt_reg),
        .wr_data (grid_reg[0]),
        .rd_en   (hist_rd_en),
        .rd_slot (hist_rd_slot),
        .rd_row  (hist_rd_row),
        .rd_data (hist_rd_data)
    );

    // edit decode: addressed row and bit, out-of-grid addresses edit nothing
    assign cx_ok      = int'(cell_x) < GRID_SIDE;
    assign cy_ok      = int'(cell_y) < GRID_SIDE;
    assign cy_idx     = ROW_W'(cell_y);
    assign bit_mask   = row_t'(1) << cell_x;
    assign old_row    = cy_ok ? grid_reg[cy_idx] : '0;
    assign row_inc    = ROW_W'(row_cnt_reg + 1'b1);

    always_comb
    begin
        unique case (cmd_t'(command))
            CMD_SET:    edited_row = cell_value ? (old_row | bit_mask) : (old_row & ~bit_mask);
            CMD_TOGGLE: edited_row = old_row ^ bit_mask;
            default:    edited_row = old_row;
        endcase
    end

    // stagnation update, saturating count
    assign stagnant  = !chg_reg || rep_reg;
    assign count_upd = stagnant ? ((stag_cnt_reg == COUNT_MAX) ? stag_cnt_reg
                                                               : stag_cnt_reg + 1'b1)
                                : '0;
    assign due       = auto_en_reg && (count_upd > limit_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (cmd_t'(command) == CMD_STEP) ? ST_STEP : ST_EDIT_OUT;
                end
            end
            ST_EDIT_OUT:
            begin
                if (out_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_STEP:
            begin
                if (row_cnt_reg == ROW_LAST)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if ((slot_cnt_reg == SLOT_LAST) && (row_cnt_reg == ROW_LAST))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_fire && (row_cnt_reg == ROW_LAST))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        grid_next      = grid_reg;
        prev_row_next  = prev_row_reg;
        first_row_next = first_row_reg;
        row_cnt_next   = row_cnt_reg;
        slot_cnt_next  = slot_cnt_reg;
        hist_slot_next = hist_slot_reg;
        stag_cnt_next  = stag_cnt_reg;
        chg_next       = chg_reg;
        rep_next       = rep_reg;
        slot_mism_next = slot_mism_reg;
        rd_vld_next    = 1'b0;
        rd_last_next   = rd_last_reg;
        cmp_row_next   = cmp_row_reg;
        out_valid_next = out_valid_reg;
        out_idx_next   = out_idx_reg;
        out_bits_next  = out_bits_reg;
        out_chg_next   = out_chg_reg;
        out_rep_next   = out_rep_reg;
        out_due_next   = out_due_reg;
        out_last_next  = out_last_reg;
        hist_wr_en     = 1'b0;
        hist_rd_en     = 1'b0;
        hist_rd_slot   = slot_cnt_reg;
        hist_rd_row    = row_cnt_reg;

        // compare stage: one history row against the grid row issued last cycle
        if (rd_vld_reg)
        begin
            if (rd_last_reg)
            begin
                if (!(slot_mism_reg || !unit_equal))
                begin
                    rep_next = 1'b1;
                end
                slot_mism_next = 1'b0;
            end
            else
            begin
                slot_mism_next = slot_mism_reg || !unit_equal;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (cmd_t'(command) == CMD_STEP)
                    begin
                        row_cnt_next   = '0;
                        prev_row_next  = grid_reg[GRID_SIDE-1];
                        first_row_next = grid_reg[0];
                        chg_next       = 1'b0;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_idx_next   = cell_y;
                        out_chg_next   = 1'b0;
                        out_rep_next   = 1'b0;
                        out_due_next   = 1'b0;
                        out_last_next  = 1'b1;
                        if (cmd_t'(command) == CMD_CLEAR)
                        begin
                            for (int k = 0; k < GRID_SIDE; k++)
                            begin
                                grid_next[k] = '0;
                            end
                            out_bits_next = '0;
                        end
                        else if (cx_ok && cy_ok)
                        begin
                            grid_next[cy_idx] = edited_row;
                            out_bits_next     = ROW_OUT_W'(edited_row);
                        end
                        else
                        begin
                            out_bits_next = ROW_OUT_W'(old_row);
                        end
                    end
                end
            end
            ST_EDIT_OUT:
            begin
                if (out_fire)
                begin
                    out_valid_next = 1'b0;
                end
            end
            ST_STEP:
            begin
                // new row enters at the tail while old rows move toward the tap
                for (int k = 0; k < GRID_SIDE - 1; k++)
                begin
                    grid_next[k] = grid_reg[k + 1];
                end
                grid_next[GRID_SIDE-1] = unit_next_row;
                prev_row_next = grid_reg[0];
                chg_next      = chg_reg || !unit_equal;
                if (row_cnt_reg == ROW_LAST)
                begin
                    row_cnt_next   = '0;
                    slot_cnt_next  = '0;
                    rep_next       = 1'b0;
                    slot_mism_next = 1'b0;
                end
                else
                begin
                    row_cnt_next = row_inc;
                end
            end
            ST_CMP:
            begin
                hist_rd_en   = 1'b1;
                rd_vld_next  = 1'b1;
                rd_last_next = (row_cnt_reg == ROW_LAST);
                cmp_row_next = grid_reg[0];
                for (int k = 0; k < GRID_SIDE - 1; k++)
                begin
                    grid_next[k] = grid_reg[k + 1];
                end
                grid_next[GRID_SIDE-1] = grid_reg[0];
                if (row_cnt_reg == ROW_LAST)
                begin
                    row_cnt_next  = '0;
                    slot_cnt_next = SLOT_W'(slot_cnt_reg + 1'b1);
                end
                else
                begin
                    row_cnt_next = row_inc;
                end
            end
            ST_DRAIN:
            begin
                row_cnt_next = '0;
            end
            ST_UPD:
            begin
                stag_cnt_next  = due ? '0 : count_upd;
                out_valid_next = 1'b1;
                out_idx_next   = '0;
                out_bits_next  = ROW_OUT_W'(grid_reg[0]);
                out_chg_next   = chg_reg;
                out_rep_next   = rep_reg;
                out_due_next   = due;
                out_last_next  = 1'b0;
            end
            ST_OUT:
            begin
                if (out_fire)
                begin
                    // the reported row is stored into the history as it leaves
                    hist_wr_en = 1'b1;
                    for (int k = 0; k < GRID_SIDE - 1; k++)
                    begin
                        grid_next[k] = grid_reg[k + 1];
                    end
                    grid_next[GRID_SIDE-1] = grid_reg[0];
                    if (row_cnt_reg == ROW_LAST)
                    begin
                        out_valid_next = 1'b0;
                        row_cnt_next   = '0;
                        hist_slot_next = (hist_slot_reg == SLOT_LAST) ? '0
                                       : SLOT_W'(hist_slot_reg + 1'b1);
                    end
                    else
                    begin
                        row_cnt_next  = row_inc;
                        out_idx_next  = COORD_W'(row_inc);
                        out_bits_next = ROW_OUT_W'(grid_reg[1]);
                        out_last_next = (row_inc == ROW_LAST);
                    end
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            for (int k = 0; k < GRID_SIDE; k++)
            begin
                grid_reg[k] <= '0;
            end
            row_cnt_reg   <= '0;
            slot_cnt_reg  <= '0;
            hist_slot_reg <= '0;
            stag_cnt_reg  <= '0;
            limit_reg     <= DEFAULT_LIMIT;
            auto_en_reg   <= 1'b0;
            chg_reg       <= 1'b0;
            rep_reg       <= 1'b0;
            slot_mism_reg <= 1'b0;
            rd_vld_reg    <= 1'b0;
            rd_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            grid_reg      <= grid_next;
            row_cnt_reg   <= row_cnt_next;
            slot_cnt_reg  <= slot_cnt_next;
            hist_slot_reg <= hist_slot_next;
            stag_cnt_reg  <= stag_cnt_next;
            chg_reg       <= chg_next;
            rep_reg       <= rep_next;
            slot_mism_reg <= slot_mism_next;
            rd_vld_reg    <= rd_vld_next;
            rd_last_reg   <= rd_last_next;
            out_valid_reg <= out_valid_next;
            // configuration writes, indexes beyond the list are dropped
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_STAGNANT_LIMIT: limit_reg   <= cfg_data;
                    CFG_AUTO_RESET:     auto_en_reg <= cfg_data[0];
                    default:            ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prev_row_reg  <= prev_row_next;
        first_row_reg <= first_row_next;
        cmp_row_reg   <= cmp_row_next;
        out_idx_reg   <= out_idx_next;
        out_bits_reg  <= out_bits_next;
        out_chg_reg   <= out_chg_next;
        out_rep_reg   <= out_rep_next;
        out_due_reg   <= out_due_next;
        out_last_reg  <= out_last_next;
    end

endmodule

// ----- rtl/lacd_checker.sv -----
// port-level checker for the life automaton core and its bind
`timescale 1ns / 1ps

module lacd_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [lacd_pkg::COORD_W-1:0]      row_index,
    input logic [lacd_pkg::ROW_OUT_W-1:0]    row_bits,
    input logic                              changed,
    input logic                              repeating,
    input logic                              reset_due,
    input logic                              last
);

    import lacd_pkg::*;

    // one request at a time: never ready while a row is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("request ready while a row result is pending");

    // a taken request closes the input until its rows are out
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready stayed high after a request");

    // the final row ends the result burst
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> !out_valid)
        else $error("result still valid after the final row");

    // auto-reset only fires on a stagnant step
    a_due_stagnant: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && reset_due) |-> (!changed || repeating))
        else $error("reset_due on a step that was not stagnant");

    // stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(row_bits) && $stable(row_index) && $stable(last)))
        else $error("result changed while stalled");

endmodule

bind life_automaton_with_cycle_detect_core lacd_checker u_lacd_checker (.*);
